@@ design/blis_pkg.sv @@
// shared constants and codes for the bounded item list store
package blis_pkg;

  localparam int DEPTH     = 64;
  localparam int ITEM_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int REQ_BITS  = 3;
  localparam int STAT_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_SET    = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_GET    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_FIND   = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd5;

  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

endpackage

@@ design/bounded_item_list_store.sv @@
// bounded item list store: ordered list kept in one single-port-read memory
// sequence: a request is accepted, executed, then its result is registered for output;
//   get reads its entry first, remove shifts later entries down, find scans from index 0
// throughput: one item at a time; remove and find step one memory entry per cycle
// reset: synchronous active-low rst_n empties the list; memory contents are not cleared
module bounded_item_list_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [blis_pkg::REQ_BITS-1:0]     in_req_type,
  input  logic [blis_pkg::IDX_BITS-1:0]     in_index,
  input  logic [blis_pkg::ITEM_BITS-1:0]    in_item_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [blis_pkg::STAT_BITS-1:0]    out_status,
  output logic [blis_pkg::ITEM_BITS-1:0]    out_item_out,
  output logic [blis_pkg::IDX_BITS-1:0]     out_found_index,
  output logic [blis_pkg::CNT_BITS-1:0]     out_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET,
    S_SHIFT,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                             state_r, state_nxt;
  logic [blis_pkg::REQ_BITS-1:0]      req_r, req_nxt;
  logic [blis_pkg::IDX_BITS-1:0]      idx_r, idx_nxt;
  logic [blis_pkg::ITEM_BITS-1:0]     item_r, item_nxt;
  logic [blis_pkg::IDX_BITS-1:0]      ptr_r, ptr_nxt;
  logic [blis_pkg::CNT_BITS-1:0]      count_r, count_nxt;
  logic [blis_pkg::STAT_BITS-1:0]     res_status_r, res_status_nxt;
  logic [blis_pkg::ITEM_BITS-1:0]     res_item_r, res_item_nxt;
  logic [blis_pkg::IDX_BITS-1:0]      res_found_r, res_found_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [blis_pkg::STAT_BITS-1:0]     out_status_r, out_status_nxt;
  logic [blis_pkg::ITEM_BITS-1:0]     out_item_r, out_item_nxt;
  logic [blis_pkg::IDX_BITS-1:0]      out_found_r, out_found_nxt;
  logic [blis_pkg::CNT_BITS-1:0]      out_count_r, out_count_nxt;

  logic [blis_pkg::ITEM_BITS-1:0]     mem [blis_pkg::DEPTH];
  logic [blis_pkg::ITEM_BITS-1:0]     rd_data_r;
  logic [blis_pkg::IDX_BITS-1:0]      rd_addr;
  logic                               mem_we;
  logic [blis_pkg::IDX_BITS-1:0]      wr_addr;
  logic [blis_pkg::ITEM_BITS-1:0]     wr_data;
  logic                               idx_ok;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_out    = out_item_r;
  assign out_found_index = out_found_r;
  assign out_count       = out_count_r;

  assign idx_ok = (blis_pkg::CNT_BITS'(idx_r) < count_r);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    item_nxt       = item_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = item_r;
    rd_addr        = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          idx_nxt   = in_index;
          item_nxt  = in_item_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = blis_pkg::ST_OK;
        res_item_nxt   = '0;
        res_found_nxt  = '0;
        state_nxt      = S_EMIT;
        case (req_r)
          blis_pkg::REQ_APPEND: begin
            if (count_r >= blis_pkg::CNT_BITS'(blis_pkg::DEPTH)) begin
              res_status_nxt = blis_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              wr_addr   = count_r[blis_pkg::IDX_BITS-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          blis_pkg::REQ_SET: begin
            if (!idx_ok) begin
              res_status_nxt = blis_pkg::ST_BAD_INDEX;
            end else begin
              mem_we  = 1'b1;
              wr_addr = idx_r;
            end
          end
          blis_pkg::REQ_GET: begin
            if (!idx_ok) begin
              res_status_nxt = blis_pkg::ST_BAD_INDEX;
            end else begin
              rd_addr   = idx_r;
              state_nxt = S_GET;
            end
          end
          blis_pkg::REQ_REMOVE: begin
            if (!idx_ok) begin
              res_status_nxt = blis_pkg::ST_BAD_INDEX;
            end else if (blis_pkg::CNT_BITS'(idx_r) + 1'b1 < count_r) begin
              rd_addr   = idx_r + 1'b1;
              ptr_nxt   = idx_r;
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
          blis_pkg::REQ_FIND: begin
            if (count_r == '0) begin
              res_status_nxt = blis_pkg::ST_NOT_FOUND;
            end else begin
              rd_addr   = '0;
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
          blis_pkg::REQ_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_GET: begin
        res_item_nxt = rd_data_r;
        state_nxt    = S_EMIT;
      end
      S_SHIFT: begin
        // rd_data_r holds the entry just above ptr
        mem_we  = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data_r;
        rd_addr = ptr_r + blis_pkg::IDX_BITS'(2);
        if (blis_pkg::CNT_BITS'(ptr_r) + blis_pkg::CNT_BITS'(2) < count_r) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        rd_addr = ptr_r + 1'b1;
        if (rd_data_r == item_r) begin
          res_found_nxt = ptr_r;
          state_nxt     = S_EMIT;
        end else if (blis_pkg::CNT_BITS'(ptr_r) + 1'b1 >= count_r) begin
          res_status_nxt = blis_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_item_nxt   = res_item_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    item_r       <= item_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ design/blis_chk.sv @@
// port-level checker for the bounded item list store, bound to the top level
module blis_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [blis_pkg::STAT_BITS-1:0]    out_status,
  input logic [blis_pkg::ITEM_BITS-1:0]    out_item_out,
  input logic [blis_pkg::IDX_BITS-1:0]     out_found_index,
  input logic [blis_pkg::CNT_BITS-1:0]     out_count
);

  // one item in flight: the input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous item in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= blis_pkg::CNT_BITS'(blis_pkg::DEPTH))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == blis_pkg::ST_FULL
      |-> out_count == blis_pkg::CNT_BITS'(blis_pkg::DEPTH))
    else $error("full reported below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != blis_pkg::ST_OK
      |-> out_item_out == '0 && out_found_index == '0)
    else $error("failed request carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_item_out)
      && $stable(out_found_index) && $stable(out_count))
    else $error("stalled result changed");

endmodule

bind bounded_item_list_store blis_chk u_blis_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_item_out    (out_item_out),
  .out_found_index (out_found_index),
  .out_count       (out_count)
);

@@ verif/tb_bounded_item_list_store.sv @@
// testbench for the bounded item list store with a request predictor
`timescale 1ns / 100ps

module tb_bounded_item_list_store;

  localparam logic [blis_pkg::REQ_BITS-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [blis_pkg::REQ_BITS-1:0] REQ_RSVD_B = 3'd7;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [blis_pkg::STAT_BITS-1:0] status;
    logic [blis_pkg::ITEM_BITS-1:0] item;
    logic [blis_pkg::IDX_BITS-1:0]  found;
    logic [blis_pkg::CNT_BITS-1:0]  count;
  } list_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [blis_pkg::REQ_BITS-1:0]  in_req_type;
  logic [blis_pkg::IDX_BITS-1:0]  in_index;
  logic [blis_pkg::ITEM_BITS-1:0] in_item_in;
  logic                           out_valid;
  logic                           out_stall;
  logic [blis_pkg::STAT_BITS-1:0] out_status;
  logic [blis_pkg::ITEM_BITS-1:0] out_item_out;
  logic [blis_pkg::IDX_BITS-1:0]  out_found_index;
  logic [blis_pkg::CNT_BITS-1:0]  out_count;

  logic [blis_pkg::ITEM_BITS-1:0] list_entries [blis_pkg::DEPTH];
  int                             list_len;
  list_result_t                   pending_results[$];
  int                             err_count;
  bit                             calm;
  int                             stall_hold;

  bounded_item_list_store uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_index        (in_index),
    .in_item_in      (in_item_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_item_out    (out_item_out),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic list_result_t apply_request(input logic [blis_pkg::REQ_BITS-1:0] req,
                                                 input logic [blis_pkg::IDX_BITS-1:0] idx,
                                                 input logic [blis_pkg::ITEM_BITS-1:0] item);
    list_result_t res;
    bit           idx_ok;
    bit           hit;
    res = '0;
    res.status = blis_pkg::ST_OK;
    idx_ok = int'(idx) < list_len;
    hit = 1'b0;
    case (req)
      blis_pkg::REQ_APPEND: begin
        if (list_len >= blis_pkg::DEPTH) begin
          res.status = blis_pkg::ST_FULL;
        end else begin
          list_entries[blis_pkg::IDX_BITS'(list_len)] = item;
          list_len++;
        end
      end
      blis_pkg::REQ_SET: begin
        if (!idx_ok) res.status = blis_pkg::ST_BAD_INDEX;
        else list_entries[idx] = item;
      end
      blis_pkg::REQ_GET: begin
        if (!idx_ok) res.status = blis_pkg::ST_BAD_INDEX;
        else res.item = list_entries[idx];
      end
      blis_pkg::REQ_REMOVE: begin
        if (!idx_ok) begin
          res.status = blis_pkg::ST_BAD_INDEX;
        end else begin
          for (int i = int'(idx); i + 1 < list_len; i++)
            list_entries[blis_pkg::IDX_BITS'(i)] = list_entries[blis_pkg::IDX_BITS'(i + 1)];
          list_len--;
        end
      end
      blis_pkg::REQ_FIND: begin
        res.status = blis_pkg::ST_NOT_FOUND;
        for (int i = 0; i < list_len; i++) begin
          if (!hit && list_entries[blis_pkg::IDX_BITS'(i)] == item) begin
            hit = 1'b1;
            res.status = blis_pkg::ST_OK;
            res.found = i[blis_pkg::IDX_BITS-1:0];
          end
        end
      end
      blis_pkg::REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = list_len[blis_pkg::CNT_BITS-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [blis_pkg::IDX_BITS-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (list_len > 0 && r < 60)
      return blis_pkg::IDX_BITS'($urandom_range(0, list_len - 1));
    if (list_len > 0 && r < 75)
      return ($urandom_range(0, 1) != 0) ? '0 : blis_pkg::IDX_BITS'(list_len - 1);
    if (r < 88 && list_len < blis_pkg::DEPTH)
      return blis_pkg::IDX_BITS'($urandom_range(list_len, blis_pkg::DEPTH - 1));
    return blis_pkg::IDX_BITS'($urandom_range(0, blis_pkg::DEPTH - 1));
  endfunction

  function automatic logic [blis_pkg::ITEM_BITS-1:0] pick_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 65) return $urandom_range(0, 7);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return {1'b1, {(blis_pkg::ITEM_BITS-1){1'b0}}};
        default: return 1;
      endcase
    end
    if (list_len > 0)
      return list_entries[blis_pkg::IDX_BITS'($urandom_range(0, list_len - 1))];
    return $urandom;
  endfunction

  task automatic send_req(input logic [blis_pkg::REQ_BITS-1:0] req,
                          input logic [blis_pkg::IDX_BITS-1:0] idx,
                          input logic [blis_pkg::ITEM_BITS-1:0] item);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_index    <= idx;
    in_item_in  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(req, idx, item));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic random_requests(input int n, input int append_pct, input int remove_pct);
    logic [blis_pkg::REQ_BITS-1:0] req;
    int                            r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < append_pct) begin
        req = blis_pkg::REQ_APPEND;
      end else if (r < append_pct + remove_pct) begin
        req = blis_pkg::REQ_REMOVE;
      end else if (r < 98) begin
        case ($urandom_range(0, 2))
          0: req = blis_pkg::REQ_SET;
          1: req = blis_pkg::REQ_GET;
          default: req = blis_pkg::REQ_FIND;
        endcase
      end else if (r == 98) begin
        req = blis_pkg::REQ_CLEAR;
      end else begin
        req = ($urandom_range(0, 1) != 0) ? REQ_RSVD_A : REQ_RSVD_B;
      end
      send_req(req, pick_index(), pick_item());
    end
  endtask

  task automatic test_empty_list();
    send_req(blis_pkg::REQ_FIND, '0, '0);
    send_req(blis_pkg::REQ_GET, '0, '0);
    send_req(blis_pkg::REQ_SET, blis_pkg::IDX_BITS'(blis_pkg::DEPTH - 1), '1);
    send_req(blis_pkg::REQ_REMOVE, '0, '0);
    send_req(REQ_RSVD_A, blis_pkg::IDX_BITS'(blis_pkg::DEPTH - 1), '1);
    send_req(REQ_RSVD_B, '0, '0);
    send_req(blis_pkg::REQ_CLEAR, '0, '0);
  endtask

  task automatic test_small_list();
    send_req(blis_pkg::REQ_APPEND, '0, '0);
    send_req(blis_pkg::REQ_APPEND, '0, '1);
    send_req(blis_pkg::REQ_APPEND, '0, 32'h8000_0000);
    send_req(blis_pkg::REQ_APPEND, '0, '0);
    send_req(blis_pkg::REQ_GET, '0, '0);
    send_req(blis_pkg::REQ_GET, blis_pkg::IDX_BITS'(3), '0);
    send_req(blis_pkg::REQ_GET, blis_pkg::IDX_BITS'(4), '0);
    send_req(blis_pkg::REQ_SET, blis_pkg::IDX_BITS'(1), 32'h0000_0001);
    send_req(blis_pkg::REQ_FIND, '0, '0);
    send_req(blis_pkg::REQ_FIND, '0, 32'h0000_0001);
    send_req(blis_pkg::REQ_FIND, '0, 32'h1234_5678);
    send_req(blis_pkg::REQ_REMOVE, '0, '0);
    send_req(blis_pkg::REQ_REMOVE, blis_pkg::IDX_BITS'(2), '0);
    send_req(blis_pkg::REQ_REMOVE, blis_pkg::IDX_BITS'(blis_pkg::DEPTH - 1), '0);
    send_req(blis_pkg::REQ_GET, '0, '0);
    send_req(blis_pkg::REQ_SET, blis_pkg::IDX_BITS'(2), 32'h5a5a_a5a5);
    send_req(REQ_RSVD_B, blis_pkg::IDX_BITS'(1), 32'hdead_beef);
    send_req(blis_pkg::REQ_CLEAR, '0, '0);
    send_req(blis_pkg::REQ_GET, '0, '0);
    send_req(blis_pkg::REQ_APPEND, '0, 32'h0000_0007);
  endtask

  task automatic test_fill_to_full();
    random_requests(250, 75, 5);
  endtask

  task automatic test_full_churn();
    random_requests(200, 48, 45);
  endtask

  task automatic test_drain();
    random_requests(200, 5, 70);
  endtask

  task automatic test_mixed();
    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      random_requests(110, $urandom_range(20, 60), $urandom_range(10, 40));
    end
    calm = 1'b0;
  endtask

  // result side backpressure
  initial begin
    out_stall = 1'b0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]: begin
            out_stall <= 1'b0;
            stall_hold = $urandom_range(0, 3);
          end
          [60:91]: begin
            out_stall <= 1'b1;
            stall_hold = $urandom_range(0, 2);
          end
          default: begin
            out_stall <= 1'b1;
            stall_hold = $urandom_range(10, 40);
          end
        endcase
      end
    end
  end

  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: status %0d item %h found %0d count %0d",
                     out_status, out_item_out, out_found_index, out_count);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_item_out !== want.item ||
              out_found_index !== want.found || out_count !== want.count) begin
            if (err_count < 10)
              $display("mismatch: want status %0d item %h found %0d count %0d, got %0d %h %0d %0d",
                       want.status, want.item, want.found, want.count,
                       out_status, out_item_out, out_found_index, out_count);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_bounded_item_list_store: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = '0;
    in_index    = '0;
    in_item_in  = '0;
    list_len    = 0;
    err_count   = 0;
    calm        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_small_list();
    test_fill_to_full();
    test_full_churn();
    test_drain();
    test_mixed();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_bounded_item_list_store: clean");
    end else begin
      $display("tb_bounded_item_list_store: errors");
    end
    $finish;
  end

endmodule
